>>> rtl/fla_pkg.sv
package fla_pkg;

  // fixed widths of the port fields
  localparam int SLOT_FIELD_W  = 10;
  localparam int COUNT_FIELD_W = 11;
  localparam int STATUS_W      = 2;

  // request codes
  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RECYCLE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED = 2'd0,
    ST_FULL     = 2'd1,
    ST_RECYCLED = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the request on an input transfer
    logic commit;  // update state and load the result register
  } cmd_t;

endpackage

>>> rtl/free_list_index_allocator.sv
// channel  | valid     | stall     | fields
// ---------+-----------+-----------+------------------------------------------------
// request  | in_valid  | in_stall  | func, slot_index
// result   | out_valid | out_stall | granted_slot, status, free_slots, used_length
//
// each request first reads the chain head's link from the link store
// (registered read port), then updates state and loads the result
// a new request is taken while the previous result still waits in its register
// a stalled result holds the block in its update cycle until the register frees
// synchronous reset empties the chain and clears the used length; the link
// store is not cleared, as only links written by a push are ever read
module free_list_index_allocator #(
  parameter int POOL_SLOTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [fla_pkg::SLOT_FIELD_W-1:0]   slot_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fla_pkg::SLOT_FIELD_W-1:0]   granted_slot,
  output logic [fla_pkg::STATUS_W-1:0]       status,
  output logic [fla_pkg::COUNT_FIELD_W-1:0]  free_slots,
  output logic [fla_pkg::COUNT_FIELD_W-1:0]  used_length
);

  fla_pkg::cmd_t cmd;

  // sequencing and handshakes
  fla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // free chain, link store and counters
  fla_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (func),
    .slot_index   (slot_index),
    .granted_slot (granted_slot),
    .status       (status),
    .free_slots   (free_slots),
    .used_length  (used_length)
  );

endmodule

>>> rtl/fla_ctrl.sv
module fla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output fla_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // handshake decode
  assign in_stall   = (state != S_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign cmd.load   = in_valid && !in_stall;
  assign cmd.commit = (state == S_EXEC) && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/fla_dp.sv
module fla_dp #(
  parameter int POOL_SLOTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fla_pkg::cmd_t                      cmd,
  input  logic                               func,
  input  logic [fla_pkg::SLOT_FIELD_W-1:0]   slot_index,
  output logic [fla_pkg::SLOT_FIELD_W-1:0]   granted_slot,
  output logic [fla_pkg::STATUS_W-1:0]       status,
  output logic [fla_pkg::COUNT_FIELD_W-1:0]  free_slots,
  output logic [fla_pkg::COUNT_FIELD_W-1:0]  used_length
);

  localparam int SLOT_W = $clog2(POOL_SLOTS);
  localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > fla_pkg::SLOT_FIELD_W) ? CNT_W : fla_pkg::SLOT_FIELD_W;
  localparam int GR_W   = (SLOT_W > fla_pkg::SLOT_FIELD_W) ? SLOT_W : fla_pkg::SLOT_FIELD_W;
  localparam int OUT_W  = (CNT_W > fla_pkg::COUNT_FIELD_W) ? CNT_W : fla_pkg::COUNT_FIELD_W;

  // link store, one next-slot link per slot
  logic [SLOT_W-1:0] link_store [POOL_SLOTS];
  logic [SLOT_W-1:0] link_rd;

  // allocator state
  logic [SLOT_W-1:0] chain_head;
  logic              chain_empty;
  logic [CNT_W-1:0]  high_water;
  logic [CNT_W-1:0]  free_total;

  // captured request
  logic                             func_q;
  logic [fla_pkg::SLOT_FIELD_W-1:0] idx_q;

  // result register
  logic [SLOT_W-1:0] granted_q;
  fla_pkg::status_t  status_q;
  logic [CNT_W-1:0]  free_q;
  logic [CNT_W-1:0]  used_q;

  // decision logic
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  hw_ext;
  logic              do_pop;
  logic              do_fresh;
  logic              do_push;
  logic [SLOT_W-1:0] chain_head_next;
  logic              chain_empty_next;
  logic [CNT_W-1:0]  high_water_next;
  logic [CNT_W-1:0]  free_total_next;
  logic [SLOT_W-1:0] granted_next;
  fla_pkg::status_t  status_next;

  assign idx_ext = CMP_W'(idx_q);
  assign hw_ext  = CMP_W'(high_water);

  assign do_pop   = (func_q == fla_pkg::FUNC_ACQUIRE) && !chain_empty;
  assign do_fresh = (func_q == fla_pkg::FUNC_ACQUIRE) && chain_empty &&
                    (high_water != CNT_W'(POOL_SLOTS));
  assign do_push  = (func_q == fla_pkg::FUNC_RECYCLE) && (idx_ext < hw_ext) &&
                    (free_total < high_water);

  always_comb begin
    chain_head_next  = chain_head;
    chain_empty_next = chain_empty;
    high_water_next  = high_water;
    free_total_next  = free_total;
    granted_next     = '0;
    status_next      = fla_pkg::ST_IGNORED;
    if (do_pop) begin
      granted_next     = chain_head;
      chain_head_next  = link_rd;
      free_total_next  = free_total - CNT_W'(1);
      chain_empty_next = (free_total == CNT_W'(1));
      status_next      = fla_pkg::ST_ACQUIRED;
    end else if (do_fresh) begin
      granted_next    = high_water[SLOT_W-1:0];
      high_water_next = high_water + CNT_W'(1);
      status_next     = fla_pkg::ST_ACQUIRED;
    end else if (func_q == fla_pkg::FUNC_ACQUIRE) begin
      status_next = fla_pkg::ST_FULL;
    end else if (do_push) begin
      chain_head_next  = idx_ext[SLOT_W-1:0];
      free_total_next  = free_total + CNT_W'(1);
      chain_empty_next = 1'b0;
      status_next      = fla_pkg::ST_RECYCLED;
    end
  end

  // link store: registered read of the chain head, write on push
  always_ff @(posedge clk) begin
    link_rd <= link_store[chain_head];
    if (cmd.commit && do_push) begin
      link_store[idx_ext[SLOT_W-1:0]] <= chain_head;
    end
  end

  // allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_head  <= '0;
      chain_empty <= 1'b1;
      high_water  <= '0;
      free_total  <= '0;
    end else if (cmd.commit) begin
      chain_head  <= chain_head_next;
      chain_empty <= chain_empty_next;
      high_water  <= high_water_next;
      free_total  <= free_total_next;
    end
  end

  // request capture and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      idx_q  <= slot_index;
    end
    if (cmd.commit) begin
      granted_q <= granted_next;
      status_q  <= status_next;
      free_q    <= free_total_next;
      used_q    <= high_water_next;
    end
  end

  // output fields, masked to the port widths
  logic [GR_W-1:0]  granted_ext;
  logic [OUT_W-1:0] free_ext;
  logic [OUT_W-1:0] used_ext;

  assign granted_ext  = GR_W'(granted_q);
  assign free_ext     = OUT_W'(free_q);
  assign used_ext     = OUT_W'(used_q);
  assign granted_slot = granted_ext[fla_pkg::SLOT_FIELD_W-1:0];
  assign free_slots   = free_ext[fla_pkg::COUNT_FIELD_W-1:0];
  assign used_length  = used_ext[fla_pkg::COUNT_FIELD_W-1:0];
  assign status       = status_q;

endmodule
